// ===== rtl/circular_deque_defines.svh =====
// Assertion macros used by the circular deque top level.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define CDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("circular_deque assertion failed");

// Next-cycle implication, checked outside of reset.
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("circular_deque assertion failed");

`endif

// ===== rtl/cdq_pkg.sv =====
// Package with the types, constants and pointer helpers of the circular deque.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data;
        logic                     empty_res;
        logic                     full_res;
    } t_out_item;

    // Memory command issued by the control block.
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_ram_cmd;

    // Outcome of one transaction, minus the element read from memory.
    typedef struct packed {
        logic ok;
        logic peek_ok;
        logic peek_fail;
        logic empty_res;
        logic full_res;
    } t_ctrl_res;

    // Current occupancy, for checks in the top level.
    typedef struct packed {
        logic empty;
        logic full;
    } t_status;

    // Clamp a written capacity into 1..DEPTH.
    function automatic logic [CAP_W-1:0] sat_cap(input logic [CAP_W-1:0] v);
        logic [CAP_W-1:0] c;
        begin
            c = v;
            if (c == '0) c = CAP_W'(1);
            if (c > CAP_MAX) c = CAP_MAX;
            return c;
        end
    endfunction

    function automatic logic [PTR_W-1:0] last_slot(input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] cm1;
        begin
            cm1 = cap - CAP_W'(1);
            return cm1[PTR_W-1:0];
        end
    endfunction

    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] nxt;
        begin
            nxt = CAP_W'(p) + CAP_W'(1);
            return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
        end
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                    input logic [CAP_W-1:0] cap);
        begin
            return (p == '0 || CAP_W'(p) >= cap) ? last_slot(cap) : p - PTR_W'(1);
        end
    endfunction

endpackage

// ===== rtl/circular_deque.sv =====
// Top level of the circular deque: handshakes, result stages and slot memory.
// A result passes through the pending stage and the output register after its transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled, set by the
// read-modify update of the pointer registers and the registered read of the slot memory.
// Reset (i_rst_n low, synchronous) empties the deque, sets capacity to 16
// and drops both result stages; slot contents are left undefined.
module circular_deque import cdq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

`include "circular_deque_defines.svh"

    // Stage one holds the control outcome while the memory read completes.
    // Stage two is the output register seen by the downstream consumer.
    logic      r_pend_valid;
    t_ctrl_res r_pend;
    logic      r_out_valid;
    t_out_item r_out;

    logic        accept;
    logic        pend_move;
    t_ram_cmd    ram_cmd;
    t_ctrl_res   ctrl_res;
    t_status     status;
    logic [DATA_W-1:0] ram_rdata;
    t_out_item   n_out;

    // The pending stage advances whenever the output register is free or
    // being emptied in this cycle, and a new transaction may enter whenever
    // the pending stage is free or advancing. The memory read therefore
    // only fires on entry, so it never overwrites data a waiting peek needs.
    assign pend_move  = r_pend_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend_valid || pend_move;
    assign accept     = i_in_valid && o_in_ready;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_ram_cmd  (ram_cmd),
        .o_res      (ctrl_res),
        .o_status   (status)
    );

    cdq_ram #(
        .ADDR_W (PTR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (ram_cmd.wdata),
        .i_re    (ram_cmd.re),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (ram_rdata)
    );

    // Only one operation runs per cycle, so a write and a read never touch
    // the memory in the same cycle; a read following a write sees it.

    // A successful peek returns the slot, a failed peek all ones, and every
    // other operation zero.
    always_comb begin
        n_out.ok        = r_pend.ok;
        n_out.empty_res = r_pend.empty_res;
        n_out.full_res  = r_pend.full_res;
        priority if (r_pend.peek_ok) begin
            n_out.data = ram_rdata;
        end else if (r_pend.peek_fail) begin
            n_out.data = '1;
        end else begin
            n_out.data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= ctrl_res;
        end
        if (pend_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The memory read data must not be overwritten while a peek waits.
    `CDQ_ASSERT_NOW(a_no_read_in_stall, i_clk, i_rst_n, r_pend_valid && !pend_move, !ram_cmd.re)
    // A single operation either writes or reads the slot memory, never both.
    `CDQ_ASSERT_NOW(a_one_mem_access, i_clk, i_rst_n, ram_cmd.we, !ram_cmd.re)
    // A successful push always leaves the deque non-empty.
    `CDQ_ASSERT_NEXT(a_push_not_empty, i_clk, i_rst_n, ram_cmd.we && !i_cfg_we, !status.empty)
    // With a capacity of at least one, a result is never both empty and full.
    `CDQ_ASSERT_NOW(a_status_exclusive, i_clk, i_rst_n, r_out_valid, !(r_out.empty_res && r_out.full_res))

endmodule

// ===== rtl/cdq_ram.sv =====
// Single-port-write, single-port-read slot memory with registered read data.
module cdq_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cdq_ctrl.sv =====
// Pointer, fill level and capacity control of the circular deque.
module cdq_ctrl import cdq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  t_in_item         i_item,
    output t_ram_cmd         o_ram_cmd,
    output t_ctrl_res        o_res,
    output t_status          o_status
);

    logic [CAP_W-1:0] r_cap,   n_cap;
    logic [PTR_W-1:0] r_front, n_front;
    logic [PTR_W-1:0] r_back,  n_back;
    logic [CAP_W-1:0] r_fill,  n_fill;

    logic is_empty;
    logic is_full;
    logic [CAP_W-1:0] cfg_cap;

    assign is_empty = (r_fill == '0);
    assign is_full  = (r_fill >= r_cap);
    assign cfg_cap  = sat_cap(i_cfg_data);

    always_comb begin
        n_cap     = r_cap;
        n_front   = r_front;
        n_back    = r_back;
        n_fill    = r_fill;
        o_ram_cmd = '0;
        o_ram_cmd.wdata = i_item.value;
        o_res     = '0;

        if (i_accept) begin
            unique case (t_op'(i_item.operation))
                OP_PUSH_FRONT: begin
                    if (!is_full) begin
                        n_front         = step_down(r_front, r_cap);
                        o_ram_cmd.we    = 1'b1;
                        o_ram_cmd.waddr = n_front;
                        n_fill          = r_fill + CAP_W'(1);
                        o_res.ok        = 1'b1;
                    end
                end
                OP_PUSH_BACK: begin
                    if (!is_full) begin
                        n_back          = step_up(r_back, r_cap);
                        o_ram_cmd.we    = 1'b1;
                        o_ram_cmd.waddr = n_back;
                        n_fill          = r_fill + CAP_W'(1);
                        o_res.ok        = 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (!is_empty) begin
                        n_front  = step_up(r_front, r_cap);
                        n_fill   = r_fill - CAP_W'(1);
                        o_res.ok = 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (!is_empty) begin
                        n_back   = step_down(r_back, r_cap);
                        n_fill   = r_fill - CAP_W'(1);
                        o_res.ok = 1'b1;
                    end
                end
                OP_PEEK_FRONT: begin
                    o_res.ok        = !is_empty;
                    o_res.peek_ok   = !is_empty;
                    o_res.peek_fail = is_empty;
                    o_ram_cmd.re    = !is_empty;
                    o_ram_cmd.raddr = r_front;
                end
                OP_PEEK_BACK: begin
                    o_res.ok        = !is_empty;
                    o_res.peek_ok   = !is_empty;
                    o_res.peek_fail = is_empty;
                    o_ram_cmd.re    = !is_empty;
                    o_ram_cmd.raddr = r_back;
                end
                default: begin
                end
            endcase
        end

        o_res.empty_res = (n_fill == '0);
        o_res.full_res  = (n_fill >= r_cap);

        // A capacity write empties the deque.
        if (i_cfg_we) begin
            n_cap   = cfg_cap;
            n_front = '0;
            n_back  = last_slot(cfg_cap);
            n_fill  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_front <= '0;
            r_back  <= last_slot(CAP_RESET);
            r_fill  <= '0;
        end else begin
            r_cap   <= n_cap;
            r_front <= n_front;
            r_back  <= n_back;
            r_fill  <= n_fill;
        end
    end

    assign o_status.empty = is_empty;
    assign o_status.full  = is_full;

endmodule

// ===== verif/tb_circular_deque.sv =====
// Self-checking testbench for the circular deque: directed corner cases, then randomized traffic.
`timescale 1ns / 1ps

module tb_circular_deque;
    import cdq_pkg::*;

    // Operation codes that the package leaves unnamed. The block must treat
    // them as no-ops that report failure.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // Percentage of cycles in which either side idles while stalls are enabled.
    localparam int IDLE_PCT = 32;

    // Clock, reset and DUT inputs. Everything starts at a known value, so
    // nothing is left undriven before the first falling edge.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_data = '0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_item;

    // When this is low, both sides run at full rate.
    logic       stalls_on = 1'b1;

    // Shadow copy of the deque, advanced once per accepted transaction.
    logic [CAP_W-1:0]         cap_now;
    logic [PTR_W-1:0]         head_ptr;
    logic [PTR_W-1:0]         tail_ptr;
    logic [CAP_W-1:0]         occupancy;
    logic signed [DATA_W-1:0] shadow_slots [DEPTH];

    // Results predicted but not yet seen on the output port, oldest first.
    t_out_item pending_results [$];
    int        mismatch_count = 0;

    circular_deque uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side stalls at random, driven on the falling edge like every
    // other input of the block.
    always @(negedge clk) begin
        out_ready <= !stalls_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Empties the shadow deque for a given raw capacity write. A zero acts as
    // a capacity of one and anything above the slot count acts as the slot count.
    function automatic void empty_shadow(input logic [CAP_W-1:0] raw_cap);
        int c;
        c = int'(raw_cap);
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        cap_now   = CAP_W'(c);
        head_ptr  = '0;
        tail_ptr  = PTR_W'(c - 1);
        occupancy = '0;
    endfunction

    // Applies one operation to the shadow deque and returns the result the
    // block should produce for it.
    function automatic t_out_item apply_deque_op(input logic [OP_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] val);
        t_out_item res;
        int        c;
        int        h;
        int        t;
        int        n;
        c = int'(cap_now);
        h = int'(head_ptr);
        t = int'(tail_ptr);
        n = int'(occupancy);
        res = '0;
        case (op)
            OP_PUSH_FRONT: begin
                if (n < c) begin
                    h = (h == 0 || h >= c) ? c - 1 : h - 1;
                    shadow_slots[h] = val;
                    n++;
                    res.ok = 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (n < c) begin
                    t = (t + 1 >= c) ? 0 : t + 1;
                    shadow_slots[t] = val;
                    n++;
                    res.ok = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (n != 0) begin
                    h = (h + 1 >= c) ? 0 : h + 1;
                    n--;
                    res.ok = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (n != 0) begin
                    t = (t == 0 || t >= c) ? c - 1 : t - 1;
                    n--;
                    res.ok = 1'b1;
                end
            end
            OP_PEEK_FRONT: begin
                if (n == 0) begin
                    res.data = '1;
                end else begin
                    res.data = shadow_slots[h];
                    res.ok   = 1'b1;
                end
            end
            OP_PEEK_BACK: begin
                if (n == 0) begin
                    res.data = '1;
                end else begin
                    res.data = shadow_slots[t];
                    res.ok   = 1'b1;
                end
            end
            default: begin
                // Spare codes change nothing and report failure.
            end
        endcase
        head_ptr      = PTR_W'(h);
        tail_ptr      = PTR_W'(t);
        occupancy     = CAP_W'(n);
        res.empty_res = (n == 0);
        res.full_res  = (n >= c);
        return res;
    endfunction

    // Result checker. Every result taken from the block is matched against
    // the oldest prediction; a result with nothing predicted is an error too.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ok=%b data=%h empty=%b full=%b",
                         $time, out_item.ok, out_item.data, out_item.empty_res,
                         out_item.full_res);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.ok !== want.ok || out_item.data !== want.data ||
                    out_item.empty_res !== want.empty_res ||
                    out_item.full_res !== want.full_res) begin
                    $display("%0t: result mismatch, expected ok=%b data=%h empty=%b full=%b, actual ok=%b data=%h empty=%b full=%b",
                             $time, want.ok, want.data, want.empty_res, want.full_res,
                             out_item.ok, out_item.data, out_item.empty_res,
                             out_item.full_res);
                    mismatch_count++;
                end
            end
        end
    end

    // Sends one transaction. It is entered and left just after a falling
    // edge. Valid is only lowered when the sender decides to idle, so a
    // back-to-back transaction keeps valid high without a glitch.
    task automatic send_op(input logic [OP_W-1:0] op,
                           input logic signed [DATA_W-1:0] val);
        t_in_item item;
        item.operation = op;
        item.value     = val;
        while (stalls_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do begin
            @(posedge clk);
        end while (!in_ready);
        // The transaction is accepted at this edge, so the prediction is queued before
        // its result can pass the pending stage and reach the output register.
        pending_results.push_back(apply_deque_op(op, val));
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has been seen.
    // Every transaction yields exactly one result, so an empty queue means
    // the block is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Writes the capacity register while the block is idle. The write also
    // empties the deque, which the shadow copy follows.
    task automatic write_capacity(input logic [CAP_W-1:0] raw_cap);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= raw_cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        empty_shadow(raw_cap);
    endtask

    // A fresh deque refuses to pop or peek, and the spare codes do nothing.
    task automatic test_empty_deque();
        send_op(OP_PEEK_FRONT, 32'sd0);
        send_op(OP_PEEK_BACK, 32'sd0);
        send_op(OP_POP_FRONT, 32'sd0);
        send_op(OP_POP_BACK, 32'sd0);
        send_op(OP_SPARE_LO, 32'sd0);
        send_op(OP_SPARE_HI, -32'sd1);
    endtask

    // Extreme values pushed at both ends come back out at the right end.
    task automatic test_push_and_peek();
        send_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_op(OP_PUSH_BACK, 32'sh8000_0000);
        send_op(OP_PEEK_FRONT, 32'sd0);
        send_op(OP_PEEK_BACK, 32'sd0);
        send_op(OP_POP_FRONT, 32'sd0);
        send_op(OP_PEEK_FRONT, 32'sd0);
        send_op(OP_POP_BACK, 32'sd0);
    endtask

    // A capacity write of zero acts as one: one push fills the deque, and
    // further pushes at either end are refused.
    task automatic test_capacity_one();
        write_capacity(CAP_W'(0));
        send_op(OP_PUSH_BACK, -32'sd1);
        send_op(OP_PUSH_FRONT, 32'sd0);
        send_op(OP_PUSH_BACK, 32'sd0);
        send_op(OP_PEEK_FRONT, 32'sd0);
        send_op(OP_SPARE_HI, 32'sd0);
        send_op(OP_POP_FRONT, 32'sd0);
        send_op(OP_POP_BACK, 32'sd0);
    endtask

    // With two slots both pointers wrap on their first move. Then a capacity
    // above the slot count, which acts as the slot count, empties the deque.
    task automatic test_wrap_and_clamp();
        write_capacity(CAP_W'(2));
        send_op(OP_PUSH_FRONT, 32'sd5);
        send_op(OP_PUSH_BACK, 32'sd6);
        send_op(OP_PEEK_FRONT, 32'sd0);
        send_op(OP_PEEK_BACK, 32'sd0);
        send_op(OP_POP_BACK, 32'sd0);
        send_op(OP_PEEK_BACK, 32'sd0);
        write_capacity(CAP_W'(31));
        send_op(OP_PEEK_FRONT, 32'sd0);
    endtask

    // Random traffic in phases, each with its own capacity. The mix leans
    // toward pushes or pops in turns so the deque keeps swinging between
    // empty and full, which is where the pointer wrap and the status flags
    // do their work.
    task automatic test_random_traffic();
        logic [CAP_W-1:0]         phase_cap;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        int                       push_pct;
        int                       pick;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0:       phase_cap = CAP_W'(16);
                1:       phase_cap = CAP_W'(1);
                2:       phase_cap = CAP_W'(3);
                3:       phase_cap = CAP_W'(31);
                4:       phase_cap = CAP_W'(0);
                5:       phase_cap = CAP_W'(17);
                default: phase_cap = CAP_W'($urandom_range(0, 31));
            endcase
            write_capacity(phase_cap);
            // One phase runs with no idling on either side.
            stalls_on = (ph != 3);
            push_pct  = 60;
            for (int i = 0; i < 80; i++) begin
                if (i % 16 == 0) push_pct = (push_pct == 60) ? 25 : 60;
                // Halfway through one phase, stop and let every result come.
                if (ph == 6 && i == 40) drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
                end else if (pick < 4 + push_pct) begin
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else if (pick < 52 + push_pct / 2) begin
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                end else begin
                    op = $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
                end
                pick = $urandom_range(0, 99);
                if (pick < 10)      val = 32'sh7FFF_FFFF;
                else if (pick < 20) val = 32'sh8000_0000;
                else if (pick < 25) val = 32'sd0;
                else if (pick < 30) val = -32'sd1;
                else                val = $urandom;
                send_op(op, val);
            end
        end
        stalls_on = 1'b1;
    endtask

    // Main sequence: reset, directed tests, random traffic, then the verdict.
    initial begin
        for (int k = 0; k < DEPTH; k++) shadow_slots[k] = '0;
        empty_shadow(CAP_RESET);
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_deque();
        test_push_and_peek();
        test_capacity_one();
        test_wrap_and_clamp();
        test_random_traffic();

        drain_results();
        // Waiting on after the drain catches any stray result that follows the last one.
        repeat (8) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== circular_deque.f =====
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/circular_deque.sv
verif/tb_circular_deque.sv
